>>> design/pkhi_pkg.sv
// ----------------------------------------------------------------------------
// pkhi_pkg
// Types, constants and codes shared by the pair key hash index unit.
// ----------------------------------------------------------------------------
package pkhi_pkg;

    // slot count, taken as a power of two (start slot is the low hash bits)
    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int KEY_DEPTH = 512;
    localparam int ENTRY_W   = $clog2(KEY_DEPTH);
    localparam int COUNT_W   = ENTRY_W + 1;
    localparam int CAPACITY  = (SLOTS / 2 < KEY_DEPTH) ? SLOTS / 2 : KEY_DEPTH;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [63:0]       key;
        logic [SLOT_W-1:0] slot;
    } t_job;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] entry;
    } t_slot;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MUL,
        HS_PUSH
    } t_hash_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SLOT_RD,
        BS_SLOT_CHK,
        BS_KEY_CHK,
        BS_OUT
    } t_back_state;

endpackage

>>> design/pkhi_req_if.sv
// ----------------------------------------------------------------------------
// pkhi_req_if
// Request channel: lookup or insert of a node pair.
// ----------------------------------------------------------------------------
interface pkhi_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] source_node;
    logic [31:0] target_node;

    modport source (output valid, req_type, source_node, target_node, input ready);
    modport sink   (input valid, req_type, source_node, target_node, output ready);
endinterface

>>> design/pkhi_rsp_if.sv
// ----------------------------------------------------------------------------
// pkhi_rsp_if
// Response channel: status and entry number.
// ----------------------------------------------------------------------------
interface pkhi_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [8:0] entry_number;

    modport source (output valid, status, entry_number, input ready);
    modport sink   (input valid, status, entry_number, output ready);
endinterface

>>> design/pkhi_hash.sv
// ----------------------------------------------------------------------------
// pkhi_hash
// Front end: takes a request, packs the key and runs the 64-bit finaliser
// on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module pkhi_hash
    import pkhi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pkhi_req_if.sink   i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_hash_state r_state, n_state;
    logic        r_pass;
    logic [1:0]  r_step;
    logic        r_req_type;
    logic [63:0] r_key;
    logic [63:0] r_k;
    logic [63:0] r_acc;
    logic [31:0] r_cross;
    logic [SLOT_W-1:0] r_slot;

    logic [63:0] w_key;
    logic [63:0] w_c;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_m;
    logic [63:0] w_prod;

    assign w_key  = {i_req.source_node, i_req.target_node};
    assign w_c    = r_pass ? MIX_C2 : MIX_C1;
    assign w_a    = (r_step == 2'd1) ? r_k[63:32] : r_k[31:0];
    assign w_b    = (r_step == 2'd2) ? w_c[63:32] : w_c[31:0];
    assign w_m    = 64'(w_a) * 64'(w_b);
    assign w_prod = {r_acc[63:32] + r_cross, r_acc[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
            r_pass  <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                HS_IDLE: begin
                    r_pass <= 1'b0;
                    r_step <= 2'd0;
                end
                HS_MUL: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_pass <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            HS_IDLE: begin
                r_req_type <= i_req.req_type;
                r_key      <= w_key;
                r_k        <= w_key ^ (w_key >> SHIFT_A);
            end
            HS_MUL: begin
                case (r_step)
                    2'd0: r_acc   <= w_m;
                    2'd1: r_cross <= w_m[31:0];
                    2'd2: r_cross <= r_cross + w_m[31:0];
                    default: begin
                        if (!r_pass) begin
                            r_k <= w_prod ^ (w_prod >> SHIFT_B);
                        end else begin
                            r_slot <= w_prod[SLOT_W-1:0] ^ w_prod[SHIFT_C +: SLOT_W];
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        o_push      = 1'b0;
        case (r_state)
            HS_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = HS_MUL;
                end
            end
            HS_MUL: begin
                if (r_step == 2'd3 && r_pass) begin
                    n_state = HS_PUSH;
                end
            end
            HS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = HS_IDLE;
                end
            end
            default: n_state = HS_IDLE;
        endcase
    end

    assign o_job = '{req_type: r_req_type, key: r_key, slot: r_slot};

endmodule

>>> design/pkhi_queue.sv
// ----------------------------------------------------------------------------
// pkhi_queue
// Short job queue between the hash front end and the probe back end.
// ----------------------------------------------------------------------------
module pkhi_queue
    import pkhi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

>>> design/pkhi_probe.sv
// ----------------------------------------------------------------------------
// pkhi_probe
// Back end: clears the slot table, then probes it linearly for each job.
// ----------------------------------------------------------------------------
module pkhi_probe
    import pkhi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_job     i_job,
    output logic     o_pop,
    pkhi_rsp_if.source o_rsp
);

    t_back_state r_state, n_state;

    t_slot              r_slot_mem [SLOTS];
    logic [63:0]        r_key_mem  [KEY_DEPTH];
    t_slot              r_slot_q;
    logic [63:0]        r_key_q;

    logic [SLOT_W-1:0]  r_clr_idx;
    logic [COUNT_W-1:0] r_count;
    logic               r_req_type;
    logic [63:0]        r_key;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_probes;
    t_status            r_status;
    logic [ENTRY_W-1:0] r_entry;

    logic               w_cap_hit;
    logic               w_last;
    logic               w_ins_ok;
    logic               w_match;
    logic [SLOT_W-1:0]  w_next_slot;
    logic               w_slot_we;
    logic [SLOT_W-1:0]  w_slot_wa;
    t_slot              w_slot_wd;

    assign w_cap_hit   = (r_count >= COUNT_W'(CAPACITY));
    assign w_last      = (r_probes == SLOT_W'(SLOTS - 1));
    assign w_ins_ok    = (r_state == BS_SLOT_CHK) && !r_slot_q.valid
                         && (r_req_type == REQ_INSERT);
    assign w_match     = (r_key_q == r_key);
    assign w_next_slot = (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + 1'b1;

    assign w_slot_we = (r_state == BS_CLEAR) || w_ins_ok;
    assign w_slot_wa = (r_state == BS_CLEAR) ? r_clr_idx : r_slot;
    assign w_slot_wd = (r_state == BS_CLEAR) ? t_slot'('0)
                                             : t_slot'{valid: 1'b1,
                                                       entry: r_count[ENTRY_W-1:0]};

    // slot table memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_wa] <= w_slot_wd;
        end
        if (r_state == BS_SLOT_RD) begin
            r_slot_q <= r_slot_mem[r_slot];
        end
    end

    // key store memory
    always_ff @(posedge i_clk) begin
        if (w_ins_ok) begin
            r_key_mem[r_count[ENTRY_W-1:0]] <= r_key;
        end
        if (r_state == BS_SLOT_CHK) begin
            r_key_q <= r_key_mem[r_slot_q.entry];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr_idx <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_ins_ok) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // job and result registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_req_type <= i_job.req_type;
                r_key      <= i_job.key;
                r_slot     <= i_job.slot;
                r_probes   <= '0;
                r_status   <= ST_FULL;
                r_entry    <= '0;
            end
            BS_SLOT_CHK: begin
                if (!r_slot_q.valid) begin
                    r_status <= (r_req_type == REQ_INSERT) ? ST_OK : ST_NOT_FOUND;
                    r_entry  <= (r_req_type == REQ_INSERT) ? r_count[ENTRY_W-1:0] : '0;
                end else if (r_req_type == REQ_INSERT) begin
                    r_slot   <= w_next_slot;
                    r_probes <= r_probes + 1'b1;
                    r_status <= ST_FULL;
                    r_entry  <= '0;
                end
            end
            BS_KEY_CHK: begin
                if (w_match) begin
                    r_status <= ST_OK;
                    r_entry  <= r_slot_q.entry;
                end else begin
                    r_slot   <= w_next_slot;
                    r_probes <= r_probes + 1'b1;
                    r_status <= ST_NOT_FOUND;
                    r_entry  <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_rsp.valid = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                if (r_clr_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_job.req_type == REQ_INSERT && w_cap_hit) ? BS_OUT
                                                                          : BS_SLOT_RD;
                end
            end
            BS_SLOT_RD: n_state = BS_SLOT_CHK;
            BS_SLOT_CHK: begin
                if (!r_slot_q.valid) begin
                    n_state = BS_OUT;
                end else if (r_req_type == REQ_INSERT) begin
                    n_state = w_last ? BS_OUT : BS_SLOT_RD;
                end else begin
                    n_state = BS_KEY_CHK;
                end
            end
            BS_KEY_CHK: begin
                n_state = (w_match || w_last) ? BS_OUT : BS_SLOT_RD;
            end
            BS_OUT: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.entry_number = r_entry;

endmodule

>>> design/pair_key_hash_index_unit.sv
// ----------------------------------------------------------------------------
// pair_key_hash_index_unit
// Open-addressing index from a pair of 32-bit node numbers to an entry number.
// ----------------------------------------------------------------------------
// usage
//   i_req  : request channel, valid/ready; req_type 0 looks a pair up,
//            1 inserts it as the next entry
//   o_rsp  : one response per request, in order; status ok, not found or
//            full, with the entry number (0 unless found or assigned)
// timing
//   the front end hashes a request on one shared 32x32 multiplier
//   (accept, then 4 steps per multiply pass) and parks it in a
//   two-deep queue; it takes the next request as soon as its job is queued
//   the back end takes a job in its idle state, then for each probed slot
//   reads and checks the slot, and on lookup of a used slot also its key
//   (slot read, key read), then holds the response until it is taken;
//   throughput is set by the hash unit while probes stay short
// reset
//   clears control state, then the back end sweeps the slot table empty,
//   one slot a cycle across all 1024 slots; requests queue up meanwhile
//   a stalled receiver holds the back end, and the queue then the front end
// ----------------------------------------------------------------------------
module pair_key_hash_index_unit
    import pkhi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pkhi_req_if.sink   i_req,
    pkhi_rsp_if.source o_rsp
);

    // front to queue
    logic w_push;
    logic w_q_full;
    t_job w_push_job;

    // queue to back
    logic w_q_valid;
    logic w_pop;
    t_job w_pop_job;

    // hash front end
    pkhi_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    // decoupling queue
    pkhi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    // probe back end with slot table and key store
    pkhi_probe u_probe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

    // no push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full) else $error("push into full queue");

    // no pop from an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid) else $error("pop from empty queue");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status != 2'd3)) else $error("bad status code");

    // a refused or missed request carries entry zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.entry_number == '0))
        else $error("nonzero entry on miss");

endmodule

>>> tb/pair_key_hash_index_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_key_hash_index_unit_tb
// Drives lookups and inserts of node pairs into the pair key hash index unit
// and checks every response against a behavioural index held in the bench.
// ----------------------------------------------------------------------------

// behavioural copy of the index plus the queue of responses it predicts
class pair_index_scoreboard;
    logic               slot_used [pkhi_pkg::SLOTS];
    logic [8:0]         slot_entry[pkhi_pkg::SLOTS];
    logic [63:0]        pair_store[pkhi_pkg::KEY_DEPTH];
    int unsigned        entry_count;
    logic [10:0]        pending_rsp[$];     // {status, entry_number}
    int unsigned        mismatches;

    function new();
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        entry_count = 0;
        mismatches  = 0;
    endfunction

    function logic [63:0] mix_pair(logic [63:0] k);
        k = k ^ (k >> pkhi_pkg::SHIFT_A);
        k = k * pkhi_pkg::MIX_C1;
        k = k ^ (k >> pkhi_pkg::SHIFT_B);
        k = k * pkhi_pkg::MIX_C2;
        k = k ^ (k >> pkhi_pkg::SHIFT_C);
        return k;
    endfunction

    // note an accepted request and queue the response it must produce
    function void note_request(logic req_type, logic [31:0] src, logic [31:0] dst);
        logic [63:0] pair_key;
        int unsigned slot;
        logic [1:0]  status;
        logic [8:0]  entry;
        pair_key = {src, dst};
        slot     = mix_pair(pair_key) % pkhi_pkg::SLOTS;
        status   = pkhi_pkg::ST_NOT_FOUND;
        entry    = '0;
        if (req_type == pkhi_pkg::REQ_INSERT) begin
            status = pkhi_pkg::ST_FULL;
            if (entry_count < pkhi_pkg::CAPACITY) begin
                for (int n = 0; n < pkhi_pkg::SLOTS; n++) begin
                    if (!slot_used[slot]) begin
                        entry = entry_count[8:0];
                        pair_store[entry] = pair_key;
                        slot_used[slot]   = 1'b1;
                        slot_entry[slot]  = entry;
                        entry_count++;
                        status = pkhi_pkg::ST_OK;
                        break;
                    end
                    slot = (slot + 1) % pkhi_pkg::SLOTS;
                end
            end
        end else begin
            for (int n = 0; n < pkhi_pkg::SLOTS; n++) begin
                if (!slot_used[slot]) break;
                if (pair_store[slot_entry[slot]] == pair_key) begin
                    status = pkhi_pkg::ST_OK;
                    entry  = slot_entry[slot];
                    break;
                end
                slot = (slot + 1) % pkhi_pkg::SLOTS;
            end
        end
        pending_rsp.push_back({status, entry});
    endfunction

    function void check_response(logic [1:0] status, logic [8:0] entry);
        logic [10:0] want;
        if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: status %0d entry %0d", status, entry);
            return;
        end
        want = pending_rsp.pop_front();
        if (want !== {status, entry}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("response mismatch: expected status %0d entry %0d, got status %0d entry %0d",
                         want[10:9], want[8:0], status, entry);
        end
    endfunction
endclass

module pair_key_hash_index_unit_tb;
    import pkhi_pkg::*;

    logic i_clk;
    logic i_rst_n;

    pkhi_req_if req_ch();
    pkhi_rsp_if rsp_ch();

    pair_key_hash_index_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    pair_index_scoreboard index_sb;

    // idling percentages for each side, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // long receiver hold-off, counted down by its own process
    int unsigned hold_cycles;

    // pairs already inserted, reused so that lookups hit
    logic [63:0] known_pairs[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous fixed limit: reset sweep plus ~1000 requests at worst pace
    initial begin
        #(20ns * 2000000);
        $display("pair_key_hash_index_unit test failed");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles  <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            index_sb.check_response(rsp_ch.status, rsp_ch.entry_number);
    end

    // offer one request, hold it until accepted, leave valid high for the next
    task automatic send_request(logic req_type, logic [31:0] src, logic [31:0] dst);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= req_type;
        req_ch.source_node <= src;
        req_ch.target_node <= dst;
        do @(posedge i_clk); while (!req_ch.ready);
        index_sb.note_request(req_type, src, dst);
        if (req_type == REQ_INSERT) known_pairs.push_back({src, dst});
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (index_sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // lookups of known pairs, fresh inserts, duplicate inserts and some misses
    task automatic random_requests(int unsigned count);
        logic [63:0] pair;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45 && known_pairs.size() != 0) begin
                pair = known_pairs[$urandom_range(known_pairs.size() - 1)];
                send_request(REQ_LOOKUP, pair[63:32], pair[31:0]);
            end else if (pick < 80) begin
                send_request(REQ_INSERT, $urandom, $urandom);
            end else if (pick < 90 && known_pairs.size() != 0) begin
                // duplicate insert of an existing pair
                pair = known_pairs[$urandom_range(known_pairs.size() - 1)];
                send_request(REQ_INSERT, pair[63:32], pair[31:0]);
            end else begin
                send_request(REQ_LOOKUP, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        index_sb           = new();
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_cycles        = 0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOOKUP;
        req_ch.source_node = '0;
        req_ch.target_node = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lookups on an empty table, field extremes, duplicates
        send_request(REQ_LOOKUP, 32'h0, 32'h0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0, 32'h0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0, 32'h0);           // duplicate pair
        send_request(REQ_LOOKUP, 32'h0, 32'h0);           // earliest entry wins
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_LOOKUP, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA); // miss
        send_request(REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(REQ_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555);

        // no idling on either side
        random_requests(150);
        drain_responses();

        // long receiver hold-off while the sender keeps offering
        hold_cycles = 400;
        random_requests(40);
        drain_responses();

        send_idle_pct = 63;
        random_requests(150);
        drain_responses();

        send_idle_pct  = 0;
        recv_stall_pct = 63;
        random_requests(150);
        drain_responses();

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        random_requests(150);

        // fill the table to capacity, then keep hitting the full case
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (index_sb.entry_count < CAPACITY)
            send_request(REQ_INSERT, $urandom, $urandom);
        recv_stall_pct = 30;
        random_requests(150);
        drain_responses();

        if (index_sb.mismatches == 0 && index_sb.pending_rsp.size() == 0)
            $display("pair_key_hash_index_unit test passed");
        else
            $display("pair_key_hash_index_unit test failed");
        $finish;
    end
endmodule
